/* hdl/stq_pkg.sv */
// Package with the shared types and constants of the sorted timer queue.
`timescale 1ns / 1ps
package stq_pkg;
    localparam int SLOTS      = 16;
    localparam int SLOT_W     = 4;
    localparam int LINK_W     = 5;
    localparam logic [31:0] NO_DUE = 32'hffffffff;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;
    localparam logic [1:0] ACT_ARM   = 2'd3;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_NO_SLOT = 2'd1;
    localparam logic [1:0] STS_WRONG   = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  slot;
        logic [31:0] delay;
        logic [3:0]  dest;
        logic [31:0] tag;
    } in_item_t;

    typedef struct packed {
        logic        reply_kind;
        logic [1:0]  status;
        logic [3:0]  slot_out;
        logic [3:0]  dest_out;
        logic [31:0] tag_out;
        logic        switch_request;
        logic        last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item
        logic do_cmd;     // run alloc/free/arm bookkeeping, prepare acknowledge
        logic tick_inc;   // advance the tick count
        logic walk_init;  // start the insertion walk at the head
        logic walk_step;  // advance the insertion walk one node
        logic link;       // splice the armed slot in
        logic pop;        // take the head as an expiry report
        logic out_load;   // place the prepared result in the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic arm_ok;     // arm command accepted and needs linking
        logic walk_done;  // insertion point found
        logic head_due;   // head exists and is due
        logic pops_left;  // report budget not used up
    } sts_t;
endpackage

/* hdl/stq_datapath.sv */
// Datapath of the timer queue: slot tables, order links, tick count and result.
`timescale 1ns / 1ps
module stq_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  stq_pkg::in_item_t in_item,
    input  logic [4:0]        task_slot,
    input  stq_pkg::cmd_t     cmd,
    input  logic              last_flag,
    output stq_pkg::sts_t     sts,
    output stq_pkg::out_item_t res
);
    import stq_pkg::*;

    logic [1:0]  state_reg [SLOTS];
    logic [31:0] deadline_reg [SLOTS];
    logic [3:0]  dest_reg [SLOTS];
    logic [31:0] tag_reg [SLOTS];
    logic [LINK_W-1:0] link_reg [SLOTS];
    logic [LINK_W-1:0] head_reg;
    logic [31:0] count_reg;
    in_item_t    item_reg;
    logic [LINK_W-1:0] cur_reg, prev_reg;
    logic [4:0]  guard_reg;
    logic [4:0]  npop_reg;
    out_item_t   pend_reg;
    logic        arm_ok_reg;

    logic [SLOT_W-1:0] free_idx;
    logic              free_found;
    logic [SLOT_W-1:0] head_s, cur_s, prev_s;
    logic [31:0]       new_dl;
    out_item_t         ack_item, rpt_item, res_next;

    assign head_s = head_reg[SLOT_W-1:0];
    assign cur_s  = cur_reg[SLOT_W-1:0];
    assign prev_s = prev_reg[SLOT_W-1:0];
    assign new_dl = deadline_reg[item_reg.slot];

    // Lowest free slot, a priority search over the state bits.
    always_comb begin
        free_idx = '0;
        free_found = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (state_reg[i] == ST_FREE) begin
                free_idx = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    // Acknowledge of a command, expiry report of the head, and the outgoing result.
    always_comb begin
        ack_item = '0;
        if (item_reg.action == ACT_ALLOC) begin
            ack_item.status   = free_found ? STS_OK : STS_NO_SLOT;
            ack_item.slot_out = free_found ? free_idx : '0;
        end else begin
            ack_item.slot_out = item_reg.slot;
            ack_item.status   = (state_reg[item_reg.slot] == ST_RUN) ? STS_WRONG
                                                                     : STS_OK;
        end
        rpt_item = '0;
        rpt_item.reply_kind     = 1'b1;
        rpt_item.status         = STS_OK;
        rpt_item.slot_out       = head_s;
        rpt_item.dest_out       = dest_reg[head_s];
        rpt_item.tag_out        = tag_reg[head_s];
        rpt_item.switch_request = {1'b0, head_s} == task_slot;
        res_next = pend_reg;
        res_next.last = last_flag;
    end

    assign sts.is_tick   = item_reg.action == ACT_TICK;
    assign sts.arm_ok    = arm_ok_reg;
    assign sts.walk_done = cur_reg[LINK_W-1] || guard_reg[4]
                           || !(deadline_reg[cur_s] < new_dl);
    assign sts.head_due  = !head_reg[LINK_W-1] && (deadline_reg[head_s] <= count_reg);
    assign sts.pops_left = !npop_reg[4];

    // Control state: slot states, head, tick count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) state_reg[i] <= ST_FREE;
            head_reg  <= LINK_W'(SLOTS);
            count_reg <= '0;
            arm_ok_reg <= 1'b0;
        end else begin
            if (cmd.tick_inc) count_reg <= count_reg + 32'd1;
            if (cmd.do_cmd) begin
                arm_ok_reg <= 1'b0;
                if (item_reg.action == ACT_ALLOC) begin
                    if (free_found) state_reg[free_idx] <= ST_ALLOC;
                end else if (state_reg[item_reg.slot] != ST_RUN) begin
                    if (item_reg.action == ACT_FREE) begin
                        state_reg[item_reg.slot] <= ST_FREE;
                    end else begin
                        state_reg[item_reg.slot] <= ST_RUN;
                        arm_ok_reg <= 1'b1;
                    end
                end
            end
            if (cmd.link && prev_reg[LINK_W-1]) head_reg <= {1'b0, item_reg.slot};
            if (cmd.pop) begin
                state_reg[head_s] <= ST_ALLOC;
                head_reg <= link_reg[head_s];
            end
        end
    end

    // Payload storage, walk registers and result.
    always_ff @(posedge aclk) begin
        if (cmd.load) item_reg <= in_item;
        if (cmd.do_cmd) begin
            pend_reg <= ack_item;
            if (item_reg.action == ACT_ARM && state_reg[item_reg.slot] != ST_RUN) begin
                dest_reg[item_reg.slot]     <= item_reg.dest;
                tag_reg[item_reg.slot]      <= item_reg.tag;
                deadline_reg[item_reg.slot] <= count_reg + item_reg.delay;
            end
        end
        if (cmd.tick_inc) npop_reg <= '0;
        if (cmd.walk_init) begin
            cur_reg   <= head_reg;
            prev_reg  <= LINK_W'(SLOTS);
            guard_reg <= '0;
        end
        if (cmd.walk_step) begin
            prev_reg  <= cur_reg;
            cur_reg   <= link_reg[cur_s];
            guard_reg <= guard_reg + 5'd1;
        end
        if (cmd.link) begin
            link_reg[item_reg.slot] <= cur_reg;
            if (!prev_reg[LINK_W-1]) link_reg[prev_s] <= {1'b0, item_reg.slot};
        end
        if (cmd.pop) begin
            npop_reg <= npop_reg + 5'd1;
            pend_reg <= rpt_item;
        end
        if (cmd.out_load) res <= res_next;
    end
endmodule

/* hdl/stq_control.sv */
// Controller state machine of the timer queue.
`timescale 1ns / 1ps
module stq_control (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  stq_pkg::sts_t sts,
    output stq_pkg::cmd_t cmd,
    output logic          last_flag
);
    import stq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DISP  = 9'b000000010,
        S_CMD   = 9'b000000100,
        S_WALK  = 9'b000001000,
        S_ACK   = 9'b000010000,
        S_CHECK = 9'b000100000,
        S_POP   = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_WAIT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;
    logic   more_reg, more_next;
    logic   stall;

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = mv_reg;
    assign stall   = mv_reg && !m_ready;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        more_next  = more_reg;
        cmd        = '0;
        last_flag  = 1'b1;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (sts.is_tick) begin
                    cmd.tick_inc = 1'b1;
                    state_next = S_CHECK;
                end else begin
                    cmd.do_cmd = 1'b1;
                    state_next = S_CMD;
                end
            end
            S_CMD: begin
                cmd.walk_init = 1'b1;
                state_next = sts.arm_ok ? S_WALK : S_ACK;
            end
            S_WALK: begin
                if (sts.walk_done) begin
                    cmd.link = 1'b1;
                    state_next = S_ACK;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_ACK: begin
                if (!stall) begin
                    cmd.out_load = 1'b1;
                    mv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CHECK: begin
                if (sts.head_due && sts.pops_left) begin
                    cmd.pop = 1'b1;
                    state_next = S_POP;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_POP: begin
                // Report is staged; decide whether it is the final one.
                more_next = sts.head_due && sts.pops_left;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                last_flag = !more_reg;
                if (!stall) begin
                    cmd.out_load = 1'b1;
                    mv_next = 1'b1;
                    state_next = more_reg ? S_WAIT : S_IDLE;
                end
            end
            S_WAIT: begin
                if (!stall) begin
                    cmd.pop = 1'b1;
                    state_next = S_POP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
            more_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            more_reg  <= more_next;
        end
    end
endmodule

/* hdl/sorted_timer_queue.sv */
// Top level of the sorted timer queue.
`timescale 1ns / 1ps
// Sorted timer queue: sixteen timer slots ordered by deadline.
// The input channel (s_valid, s_ready, s_data) carries one command per
// transfer: tick, allocate, free or arm. The result channel (m_valid,
// m_ready, m_data) returns one acknowledge per command and one expiry
// report per due timer on a tick; last marks the final result of an item.
// A tick with nothing due gives no result.
// An arm runs an insertion walk over the order links, a step per running
// timer ahead of the new deadline, at most 16 steps. A tick pops the due
// timers from the head one at a time, one expiry report each.
// One item is in work at a time; s_ready is high only while idle.
// The result stays in the output register until taken; a stalled receiver
// holds the block at the next result.
// cfg_we and cfg_data write task_slot; the user must write it only while
// the block is idle; the block itself does not enforce this.
// Reset (aresetn low, synchronous) frees all slots, clears the tick count,
// empties the queue and sets task_slot to 16 (none).
module sorted_timer_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  stq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output stq_pkg::out_item_t m_data
);
    import stq_pkg::*;

    logic [4:0] task_slot_reg;
    cmd_t cmd;
    sts_t sts;
    logic last_flag;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) task_slot_reg <= 5'd16;
        else if (cfg_we) task_slot_reg <= cfg_data;
    end

    stq_control u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd),
        .last_flag(last_flag)
    );

    stq_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_item(s_data), .task_slot(task_slot_reg),
        .cmd(cmd), .last_flag(last_flag), .sts(sts), .res(m_data)
    );
endmodule
